// ===== rtl/ksh_pkg.sv =====
// Shared types, constants and helpers for the keyed SipHash block.
package ksh_pkg;

    localparam int WORD_W = 64;
    localparam int TAIL_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'd1;

    // Initialization constants
    localparam logic [WORD_W-1:0] INIT_C0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] INIT_C1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] INIT_C2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] INIT_C3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FIN_XOR = 64'h00000000000000ff;

    // Round schedule, counted from zero
    localparam logic [CNT_W-1:0] RND_ABSORB_END = 4'd1;
    localparam logic [CNT_W-1:0] RND_FIN_MID    = 4'd5;
    localparam logic [CNT_W-1:0] RND_FIN_END    = 4'd9;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } ksh_lanes_t;

    // Core status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } ksh_stat_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned r);
        rotl = (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic ksh_lanes_t arm(input logic [WORD_W-1:0] k0,
                                       input logic [WORD_W-1:0] k1);
        arm.v0 = k0 ^ INIT_C0;
        arm.v1 = k1 ^ INIT_C1;
        arm.v2 = k0 ^ INIT_C2;
        arm.v3 = k1 ^ INIT_C3;
    endfunction

endpackage

// ===== rtl/keyed_sip_hash_64.sv =====
// Keyed 64-bit SipHash variant: key registers, core and output register.
// A non-last word holds s_ready low until its absorb rounds are done.
// A last word runs 10 rounds; hash appears on m_valid the cycle after round 10.
// The core takes no new word until the rounds of the current word finish; this
//   is set by the single round unit that is reused for every round.
// Reset (aresetn low, synchronous) clears both keys, closes any open message
//   and drops m_valid; lanes reload from the keys when the next message starts.
module keyed_sip_hash_64 (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ksh_pkg::WORD_W-1:0]          s_data_word,
    input  logic [ksh_pkg::TAIL_W-1:0]          s_tail_bytes,
    input  logic                                s_is_last,
    // hash results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ksh_pkg::WORD_W-1:0]          m_hash_value,
    // key writes
    input  logic                                cfg_wr_en,
    input  logic [ksh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ksh_pkg::WORD_W-1:0]          cfg_wdata
);

    logic [ksh_pkg::WORD_W-1:0] key_low_reg, key_low_next;
    logic [ksh_pkg::WORD_W-1:0] key_high_reg, key_high_next;
    logic                       m_valid_reg, m_valid_next;
    logic [ksh_pkg::WORD_W-1:0] hash_reg, hash_next;

    ksh_pkg::ksh_stat_t         stat;
    logic [ksh_pkg::WORD_W-1:0] core_hash;
    logic [ksh_pkg::CNT_W-1:0]  round_cnt;
    logic                       accept, out_free;

    assign s_ready  = stat.idle;
    assign accept   = s_valid && s_ready;
    // output register can take a new hash this cycle
    assign out_free = !m_valid_reg || m_ready;

    // Key writes land directly; a message in flight already holds its lanes,
    // so new keys only show at the next message start.
    always_comb begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                ksh_pkg::REG_KEY_LOW:  key_low_next  = cfg_wdata;
                ksh_pkg::REG_KEY_HIGH: key_high_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    ksh_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .data_word  (s_data_word),
        .tail_bytes (s_tail_bytes),
        .is_last    (s_is_last),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .out_free   (out_free),
        .stat       (stat),
        .hash       (core_hash),
        .round_cnt  (round_cnt)
    );

    // Output register: loads on the last round of a message, which the core
    // only runs once the register is free.
    always_comb begin
        m_valid_next = m_valid_reg;
        hash_next    = hash_reg;
        if (stat.done) begin
            m_valid_next = 1'b1;
            hash_next    = core_hash;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;

    // an accepted word always occupies the round unit for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("core idle right after accepting a word");

    // round counter never runs past the finalization schedule
    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.idle |-> (round_cnt <= ksh_pkg::RND_FIN_END))
        else $error("round counter out of range");

    // a hash is never produced into an occupied output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> out_free)
        else $error("hash finished while output register full");

    // a new hash comes only from a busy core
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> !s_ready)
        else $error("done raised while core idle");

endmodule

// ===== rtl/ksh_round.sv =====
// One SipRound over the four lanes, shared by every round step.
module ksh_round (
    input  ksh_pkg::ksh_lanes_t lanes_in,
    output ksh_pkg::ksh_lanes_t lanes_out
);

    logic [ksh_pkg::WORD_W-1:0] a0, a1, a2, a3;
    logic [ksh_pkg::WORD_W-1:0] b0, b1, b2, b3;

    always_comb begin
        a0 = lanes_in.v0 + lanes_in.v1;
        a2 = lanes_in.v2 + lanes_in.v3;
        a1 = ksh_pkg::rotl(lanes_in.v1, 13) ^ a0;
        a3 = ksh_pkg::rotl(lanes_in.v3, 16) ^ a2;
        a0 = ksh_pkg::rotl(a0, 32);
        b2 = a2 + a1;
        b0 = a0 + a3;
        b1 = ksh_pkg::rotl(a1, 17) ^ b2;
        b3 = ksh_pkg::rotl(a3, 21) ^ b0;
        b2 = ksh_pkg::rotl(b2, 32);
        lanes_out.v0 = b0;
        lanes_out.v1 = b1;
        lanes_out.v2 = b2;
        lanes_out.v3 = b3;
    end

endmodule

// ===== rtl/ksh_core.sv =====
// Lane registers, byte count and round sequencer around the shared round unit.
module ksh_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ksh_pkg::WORD_W-1:0]  data_word,
    input  logic [ksh_pkg::TAIL_W-1:0]  tail_bytes,
    input  logic                        is_last,
    input  logic [ksh_pkg::WORD_W-1:0]  key_low,
    input  logic [ksh_pkg::WORD_W-1:0]  key_high,
    input  logic                        out_free,
    output ksh_pkg::ksh_stat_t          stat,
    output logic [ksh_pkg::WORD_W-1:0]  hash,
    output logic [ksh_pkg::CNT_W-1:0]   round_cnt
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                       state_reg, state_next;
    logic [ksh_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       open_reg, open_next;
    logic                       last_reg, last_next;
    ksh_pkg::ksh_lanes_t        lanes_reg, lanes_next;
    logic [ksh_pkg::WORD_W-1:0] word_reg, word_next;
    logic [ksh_pkg::WORD_W-1:0] count_reg, count_next;

    ksh_pkg::ksh_lanes_t        base, rnd;
    logic [ksh_pkg::WORD_W-1:0] mask, word_in, count_base;
    logic [ksh_pkg::CNT_W-1:0]  end_cnt;
    logic                       adv, done;

    ksh_round u_round (
        .lanes_in  (lanes_reg),
        .lanes_out (rnd)
    );

    // keep only the low tail bytes of a last word
    always_comb begin
        for (int b = 0; b < ksh_pkg::WORD_W / 8; b++) begin
            mask[8*b +: 8] = (is_last && (b >= int'(tail_bytes))) ? 8'h00 : 8'hff;
        end
        word_in = data_word & mask;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        open_next  = open_reg;
        last_next  = last_reg;
        lanes_next = lanes_reg;
        word_next  = word_reg;
        count_next = count_reg;
        done       = 1'b0;
        base       = open_reg ? lanes_reg : ksh_pkg::arm(key_low, key_high);
        count_base = open_reg ? count_reg : '0;
        end_cnt    = last_reg ? ksh_pkg::RND_FIN_END : ksh_pkg::RND_ABSORB_END;
        // final step waits until the output register is free
        adv        = !(last_reg && (cnt_reg == ksh_pkg::RND_FIN_END)) || out_free;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    lanes_next    = base;
                    lanes_next.v3 = base.v3 ^ word_in;
                    word_next     = word_in;
                    last_next     = is_last;
                    count_next    = count_base + (is_last
                                    ? {{(ksh_pkg::WORD_W-ksh_pkg::TAIL_W){1'b0}}, tail_bytes}
                                    : ksh_pkg::WORD_W'(8));
                    cnt_next      = '0;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (adv) begin
                    lanes_next = rnd;
                    if (cnt_reg == ksh_pkg::RND_ABSORB_END) begin
                        lanes_next.v0 = rnd.v0 ^ word_reg;
                        if (last_reg) begin
                            lanes_next.v2 = rnd.v2 ^ ksh_pkg::FIN_XOR;
                        end
                    end
                    if (last_reg && (cnt_reg == ksh_pkg::RND_FIN_MID)) begin
                        lanes_next.v0 = rnd.v0 ^ count_reg;
                    end
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == end_cnt) begin
                        state_next = ST_IDLE;
                        open_next  = !last_reg;
                        done       = last_reg;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            open_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            open_reg  <= open_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        lanes_reg <= lanes_next;
        word_reg  <= word_next;
        count_reg <= count_next;
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = done;
    assign hash      = rnd.v0 ^ rnd.v1 ^ rnd.v2 ^ rnd.v3;
    assign round_cnt = cnt_reg;

endmodule
